// File: design/bitmap_index_allocator_defines.svh
// assertion macros for the bitmap index allocator
`ifndef BITMAP_INDEX_ALLOCATOR_DEFINES_SVH
`define BITMAP_INDEX_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BIA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BIA_ASSERT(label, prop, msg)
`define BIA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/bia_pkg.sv
`default_nettype none
package bia_pkg;

  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int IDX_W      = 10;
  localparam int SLOT_CNT_W = 17;
  localparam int SLOT_COUNT = 1024;
  localparam int MAP_WORDS  = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_NONE  = 2'd1,
    ST_FREED = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REL_RD,
    S_REL_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_res_t;

endpackage
`default_nettype wire

// File: design/bia_ram.sv
`default_nettype none
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/bia_find_zero.sv
`default_nettype none
module bia_find_zero
  import bia_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  output find_res_t            res
);

  localparam int GROUPS = WORD_BITS / 8;

  logic [GROUPS-1:0] grp_found;
  logic [2:0]        grp_bit [GROUPS];

  // lowest clear bit inside each byte
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_found[g] = 1'b0;
      grp_bit[g]   = '0;
      for (int b = 7; b >= 0; b--) begin
        if (!word[g*8 + b]) begin
          grp_found[g] = 1'b1;
          grp_bit[g]   = 3'(b);
        end
      end
    end
  end

  // lowest byte that has one
  always_comb begin
    res.found   = 1'b0;
    res.bit_idx = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_found[g]) begin
        res.found   = 1'b1;
        res.bit_idx = {3'(g), grp_bit[g]};
      end
    end
  end

endmodule
`default_nettype wire

// File: design/bitmap_index_allocator.sv
`default_nettype none
// First-fit slot allocator over a bitmap of used slots (1024 slots, held as
// sixteen 64-bit words in a RAM with registered read). An input word carries
// the opcode in s_tuser (0 allocate, 1 release) and the slot in s_tdata; one
// result word comes back per input word with the status in m_tuser (0
// allocated, 1 none free, 2 released, 3 release out of range) and the
// granted index in m_tdata, zero unless allocated. Input is taken only while
// idle, and one item is in work at a time. An allocate scans the map from
// word 0 upward, one map word per cycle through the RAM read port and a
// 64-bit first-zero finder, and stops at the first word with a free bit or
// after the last word when the map is full. A release reads the map word,
// clears the bit and writes it back; an out-of-range release goes straight
// to the result. A finished result waits in the output register, so the
// next item is taken while it is still unread. Reset clears the map at once
// through one valid flag per map word; a word never written reads as all
// free, so no clearing pass is needed.
`include "bitmap_index_allocator_defines.svh"
module bitmap_index_allocator
  import bia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] slot_index, [15:10] zero
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] granted_index, [15:10] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

  state_e state, state_next;

  // request and scan bookkeeping
  logic [IDX_W-1:0]   op_idx;
  logic [WADDR_W-1:0] scan_addr;    // next map word to read
  logic               issued_all;   // every map word has been read
  logic               chk_valid;    // ram output holds word chk_addr
  logic [WADDR_W-1:0] chk_addr;
  logic [MAP_WORDS-1:0] word_valid; // word written since reset

  // finished result, then output register
  logic [IDX_W-1:0] res_idx;
  status_e          res_st;
  logic [IDX_W-1:0] out_idx;
  status_e          out_st;

  // ram port
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0]  cur_word;
  find_res_t             fr;
  logic [SLOT_CNT_W-1:0] alloc_slot;
  logic                  alloc_ok;
  logic [SLOT_CNT_W-1:0] in_slot;
  logic                  in_range;
  logic [SLOT_CNT_W-1:0] rel_slot;
  logic [WADDR_W-1:0]    rel_word;
  logic                  accept;
  logic                  out_load;

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bia_find_zero u_find (
    .word (cur_word),
    .res  (fr)
  );

  // datapath around the map word under check
  always_comb begin
    cur_word   = word_valid[chk_addr] ? ram_rdata : '0;  // unwritten word is all free
    alloc_slot = SLOT_CNT_W'({chk_addr, fr.bit_idx});
    alloc_ok   = fr.found && (alloc_slot < SLOT_CNT_W'(SLOT_COUNT));
    in_slot    = SLOT_CNT_W'(s_tdata[IDX_W-1:0]);
    in_range   = in_slot < SLOT_CNT_W'(SLOT_COUNT);
    rel_slot   = SLOT_CNT_W'(op_idx);
    rel_word   = rel_slot[WADDR_W+BIT_W-1:BIT_W];
    accept     = s_tvalid && s_tready;
    out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == OP_ALLOC) begin
            state_next = S_SCAN;
          end else if (in_range) begin
            state_next = S_REL_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if ((chk_valid && fr.found) || (!chk_valid && issued_all)) begin
          state_next = S_DONE;
        end
      end
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine: input ready and ram control
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = chk_addr;
    ram_wdata = cur_word;
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: begin
        ram_re = !issued_all;
        if (chk_valid && alloc_ok) begin
          ram_we    = 1'b1;
          ram_wdata = cur_word | (WORD_BITS'(1) << fr.bit_idx);
        end
      end
      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rel_word;
      end
      S_REL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = cur_word & ~(WORD_BITS'(1) << op_idx[BIT_W-1:0]);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_valid <= '0;
      chk_valid  <= 1'b0;
      issued_all <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        word_valid[ram_waddr] <= 1'b1;
      end
      if (accept) begin
        chk_valid  <= 1'b0;
        issued_all <= 1'b0;
      end else if (state == S_SCAN) begin
        chk_valid <= !issued_all;
        if (!issued_all && scan_addr == LAST_WORD) begin
          issued_all <= 1'b1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_idx    <= s_tdata[IDX_W-1:0];
      scan_addr <= '0;
      res_idx   <= '0;
      res_st    <= ST_RANGE;
    end
    if (state == S_SCAN) begin
      if (!issued_all) begin
        chk_addr  <= scan_addr;
        scan_addr <= scan_addr + WADDR_W'(1);
      end
      if (chk_valid && alloc_ok) begin
        res_idx <= alloc_slot[IDX_W-1:0];
        res_st  <= ST_ALLOC;
      end else begin
        res_idx <= '0;
        res_st  <= ST_NONE;  // first free bit past the slot count, or map full
      end
    end
    if (state == S_REL_RD) begin
      chk_addr <= rel_word;
    end
    if (state == S_REL_WR) begin
      res_idx <= '0;
      res_st  <= ST_FREED;
    end
    if (out_load) begin
      out_idx <= res_idx;
      out_st  <= res_st;
    end
  end

  assign m_tdata = {6'b0, out_idx};
  assign m_tuser = out_st;

  // map writes only from the scan hit or the release write-back
  `BIA_ASSERT(a_we_state, ram_we |-> (state == S_SCAN || state == S_REL_WR),
              "stray map write")
  // an allocate sets exactly one more bit in the word
  `BIA_ASSERT(a_alloc_one_bit,
              (ram_we && state == S_SCAN) |->
                ($countones(ram_wdata) == $countones(cur_word) + 1),
              "allocate did not set one bit")
  // only an allocated result carries an index
  `BIA_ASSERT(a_idx_zero, (m_tvalid && m_tuser != ST_ALLOC) |-> (m_tdata == 16'd0),
              "index on a non-allocate result")
  // an accepted item always leaves idle
  `BIA_ASSERT(a_accept_busy, accept |=> (state != S_IDLE), "accepted item dropped")

endmodule
`default_nettype wire
